// ===== hdl/tfn_pkg.sv =====
package tfn_pkg;

	// Field widths at the ports.
	localparam int IN_W   = 24;
	localparam int UNIT_W = 16;

	// Internal widths: exact edge difference and exact cross product of two unit edges.
	localparam int EDGE_W  = IN_W + 1;
	localparam int CROSS_W = 31;

	// Unit length in Q2.14 and the quotient bits needed to reach it.
	localparam int UNIT_SH  = 14;
	localparam int QUO_W    = UNIT_SH + 1;
	localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(16384);

	typedef logic [UNIT_W-1:0]  unit_t;
	typedef unit_t [2:0]        unit_vec_t;
	typedef logic [EDGE_W-1:0]  edge_t;
	typedef edge_t [2:0]        edge_vec_t;
	typedef logic [CROSS_W-1:0] cross_t;
	typedef cross_t [2:0]       cross_vec_t;

	// Tangent and binormal with their zero-length flags, carried beside the normal path.
	typedef struct packed {
		unit_vec_t tan;
		unit_vec_t bin;
		logic      tan_zero;
		logic      bin_zero;
	} side_t;

	// What travels through the square root of the cross product.
	typedef struct packed {
		cross_vec_t cr;
		side_t      side;
	} cross_pay_t;

endpackage

// ===== hdl/triangle_face_normal.sv =====
// Triangle face normal: takes one triangle per transaction (three Q8.16 vertices) and returns
// the unit tangent (first - second), unit binormal (first - third) and unit face normal
// (tangent x binormal), all Q2.14, with a degenerate flag when any of the three vectors has
// zero length. A new triangle is accepted every clock cycle while no result waits on m_tready;
// each result passes through the two square-root pipelines (25 and 31 stages), the two
// unit-scaling divider pipelines (15 stages each) and nine stages of edge, cross-product and
// output registers. The whole pipeline holds while a result waits on m_tready.
module triangle_face_normal (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
	input  logic [215:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
	// binormal_x, binormal_y, binormal_z
	output logic [143:0] m_tdata,
	// degenerate
	output logic         m_tuser
);

	import tfn_pkg::*;

	localparam int ESQ_W = 2 * (EDGE_W - 1);
	localparam int CSQ_W = 2 * (CROSS_W - 1);
	localparam int EN_W  = EDGE_W;
	localparam int CN_W  = CROSS_W;

	logic adv;

	// The pipeline moves whenever the output register is free or being emptied.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Stage 1: edges.
	logic      v_s1;
	edge_vec_t tan_s1, bin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				tan_s1[c] <= {s_tdata[IN_W*c + IN_W-1], s_tdata[IN_W*c +: IN_W]}
				           - {s_tdata[IN_W*(3+c) + IN_W-1], s_tdata[IN_W*(3+c) +: IN_W]};
				bin_s1[c] <= {s_tdata[IN_W*c + IN_W-1], s_tdata[IN_W*c +: IN_W]}
				           - {s_tdata[IN_W*(6+c) + IN_W-1], s_tdata[IN_W*(6+c) +: IN_W]};
			end
		end
	end

	// Stage 2: squared magnitudes of the edge components.
	logic                     v_s2;
	edge_vec_t                tan_s2, bin_s2;
	logic [1:0][2:0][ESQ_W-1:0] esq_s2;
	logic [1:0][2:0][EDGE_W-2:0] emag;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			emag[0][c] = (EDGE_W-1)'(tan_s1[c][EDGE_W-1] ? ~tan_s1[c] + EDGE_W'(1) : tan_s1[c]);
			emag[1][c] = (EDGE_W-1)'(bin_s1[c][EDGE_W-1] ? ~bin_s1[c] + EDGE_W'(1) : bin_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tan_s2 <= tan_s1;
			bin_s2 <= bin_s1;
			for (int e = 0; e < 2; e++) begin
				for (int c = 0; c < 3; c++) begin
					esq_s2[e][c] <= ESQ_W'(emag[e][c]) * ESQ_W'(emag[e][c]);
				end
			end
		end
	end

	// Stage 3: squared lengths.
	logic                      v_s3;
	edge_vec_t                 tan_s3, bin_s3;
	logic [1:0][2*EN_W-1:0]    elen2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tan_s3 <= tan_s2;
			bin_s3 <= bin_s2;
			for (int e = 0; e < 2; e++) begin
				elen2_s3[e] <= (2*EN_W)'(esq_s2[e][0]) + (2*EN_W)'(esq_s2[e][1])
				             + (2*EN_W)'(esq_s2[e][2]);
			end
		end
	end

	// Edge lengths.
	logic                        er_valid;
	logic [1:0][EN_W-1:0]        er_root;
	logic [$bits(edge_vec_t)*2-1:0] er_pay;

	tfn_isqrt #(
		.N     (EN_W),
		.LANES (2),
		.PW    ($bits(edge_vec_t) * 2)
	) u_edge_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.in_rad    (elen2_s3),
		.in_pay    ({bin_s3, tan_s3}),
		.out_valid (er_valid),
		.out_root  (er_root),
		.out_pay   (er_pay)
	);

	// Unit edges.
	logic                  eu_valid;
	logic [1:0][2:0][UNIT_W-1:0] eu_unit;
	logic [1:0]            eu_zero;
	logic                  eu_spare;

	tfn_unitdiv #(
		.DW    (EDGE_W),
		.LW    (EN_W),
		.LANES (2),
		.PW    (1)
	) u_edge_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (er_valid),
		.in_len    (er_root),
		.in_vec    (er_pay),
		.in_pay    (1'b0),
		.out_valid (eu_valid),
		.out_unit  (eu_unit),
		.out_zero  (eu_zero),
		.out_pay   (eu_spare)
	);

	// Stage 4: registered unit edges.
	logic  v_s4;
	side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= eu_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4.tan      <= eu_unit[0];
			side_s4.bin      <= eu_unit[1];
			side_s4.tan_zero <= eu_zero[0] | eu_spare;
			side_s4.bin_zero <= eu_zero[1];
		end
	end

	// Stage 5: the six partial products of the cross product.
	logic              v_s5;
	side_t             side_s5;
	logic [5:0][31:0]  prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5    <= side_s4;
			prod_s5[0] <= $signed(side_s4.tan[1]) * $signed(side_s4.bin[2]);
			prod_s5[1] <= $signed(side_s4.tan[2]) * $signed(side_s4.bin[1]);
			prod_s5[2] <= $signed(side_s4.tan[2]) * $signed(side_s4.bin[0]);
			prod_s5[3] <= $signed(side_s4.tan[0]) * $signed(side_s4.bin[2]);
			prod_s5[4] <= $signed(side_s4.tan[0]) * $signed(side_s4.bin[1]);
			prod_s5[5] <= $signed(side_s4.tan[1]) * $signed(side_s4.bin[0]);
		end
	end

	// Stage 6: cross product components.
	logic       v_s6;
	side_t      side_s6;
	cross_vec_t cr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= side_s5;
			for (int c = 0; c < 3; c++) begin
				cr_s6[c] <= CROSS_W'(prod_s5[2*c] - prod_s5[2*c+1]);
			end
		end
	end

	// Stage 7: squared magnitudes of the cross components.
	logic                       v_s7;
	side_t                      side_s7;
	cross_vec_t                 cr_s7;
	logic [2:0][CSQ_W-1:0]      csq_s7;
	logic [2:0][CROSS_W-2:0]    cmag;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			cmag[c] = (CROSS_W-1)'(cr_s6[c][CROSS_W-1] ? ~cr_s6[c] + CROSS_W'(1) : cr_s6[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_s6;
			cr_s7   <= cr_s6;
			for (int c = 0; c < 3; c++) begin
				csq_s7[c] <= CSQ_W'(cmag[c]) * CSQ_W'(cmag[c]);
			end
		end
	end

	// Stage 8: squared length of the cross product.
	logic             v_s8;
	cross_pay_t       cpay_s8;
	logic [2*CN_W-1:0] clen2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cpay_s8.cr   <= cr_s7;
			cpay_s8.side <= side_s7;
			clen2_s8     <= (2*CN_W)'(csq_s7[0]) + (2*CN_W)'(csq_s7[1])
			              + (2*CN_W)'(csq_s7[2]);
		end
	end

	// Cross product length.
	logic             cr_valid;
	logic [CN_W-1:0]  cr_root;
	cross_pay_t       cr_pay;

	tfn_isqrt #(
		.N     (CN_W),
		.LANES (1),
		.PW    ($bits(cross_pay_t))
	) u_cross_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s8),
		.in_rad    (clen2_s8),
		.in_pay    (cpay_s8),
		.out_valid (cr_valid),
		.out_root  (cr_root),
		.out_pay   (cr_pay)
	);

	// Unit normal.
	logic      nu_valid;
	unit_vec_t nu_unit;
	logic      nu_zero;
	side_t     nu_side;

	tfn_unitdiv #(
		.DW    (CROSS_W),
		.LW    (CN_W),
		.LANES (1),
		.PW    ($bits(side_t))
	) u_cross_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (cr_valid),
		.in_len    (cr_root),
		.in_vec    (cr_pay.cr),
		.in_pay    (cr_pay.side),
		.out_valid (nu_valid),
		.out_unit  (nu_unit),
		.out_zero  (nu_zero),
		.out_pay   (nu_side)
	);

	// Stage 9: output register.
	logic         m_tvalid_s9;
	logic [143:0] m_tdata_s9;
	logic         m_tuser_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_s9 <= 1'b0;
		end else if (adv) begin
			m_tvalid_s9 <= nu_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_s9 <= {nu_side.bin[2], nu_side.bin[1], nu_side.bin[0],
			               nu_side.tan[2], nu_side.tan[1], nu_side.tan[0],
			               nu_unit[2], nu_unit[1], nu_unit[0]};
			m_tuser_s9 <= nu_zero | nu_side.tan_zero | nu_side.bin_zero;
		end
	end

	assign m_tvalid = m_tvalid_s9;
	assign m_tdata  = m_tdata_s9;
	assign m_tuser  = m_tuser_s9;

endmodule

// ===== hdl/tfn_isqrt.sv =====
// Pipelined integer square root, rounded down, one root bit per stage.
module tfn_isqrt #(
	parameter int N     = 25,
	parameter int LANES = 2,
	parameter int PW    = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][2*N-1:0]    in_rad,
	input  logic [PW-1:0]                in_pay,
	output logic                         out_valid,
	output logic [LANES-1:0][N-1:0]      out_root,
	output logic [PW-1:0]                out_pay
);

	logic                        valid_s [0:N];
	logic [LANES-1:0][2*N-1:0]   rad_s   [0:N];
	logic [LANES-1:0][N+1:0]     rem_s   [0:N];
	logic [LANES-1:0][N-1:0]     root_s  [0:N];
	logic [PW-1:0]               pay_s   [0:N];

	// Stage zero is the input itself.
	assign valid_s[0] = in_valid;
	assign rad_s[0]   = in_rad;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign pay_s[0]   = in_pay;

	genvar g;
	for (g = 0; g < N; g++) begin : g_stage
		logic [LANES-1:0][2*N-1:0] rad_n;
		logic [LANES-1:0][N+1:0]   rem_n;
		logic [LANES-1:0][N-1:0]   root_n;

		// Bring down two radicand bits and try the next root bit.
		always_comb begin
			logic [N+1:0] cur;
			logic [N+1:0] trial;
			for (int l = 0; l < LANES; l++) begin
				cur      = {rem_s[g][l][N-1:0], rad_s[g][l][2*N-1:2*N-2]};
				trial    = {root_s[g][l], 2'b01};
				rad_n[l] = {rad_s[g][l][2*N-3:0], 2'b00};
				if (cur >= trial) begin
					rem_n[l]  = cur - trial;
					root_n[l] = {root_s[g][l][N-2:0], 1'b1};
				end else begin
					rem_n[l]  = cur;
					root_n[l] = {root_s[g][l][N-2:0], 1'b0};
				end
			end
		end

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		// Data of this stage.
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1]  <= rad_n;
				rem_s[g+1]  <= rem_n;
				root_s[g+1] <= root_n;
				pay_s[g+1]  <= pay_s[g];
			end
		end
	end

	assign out_valid = valid_s[N];
	assign out_root  = root_s[N];
	assign out_pay   = pay_s[N];

endmodule

// ===== hdl/tfn_unitdiv.sv =====
// Pipelined scaling of three-component vectors to unit length in Q2.14:
// each component becomes round(d * 16384 / len), half away from zero, by
// restoring division with one quotient bit per stage.
module tfn_unitdiv #(
	parameter int DW    = 25,
	parameter int LW    = 25,
	parameter int LANES = 2,
	parameter int PW    = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [LANES-1:0][LW-1:0]               in_len,
	input  logic [LANES-1:0][2:0][DW-1:0]          in_vec,
	input  logic [PW-1:0]                          in_pay,
	output logic                                   out_valid,
	output logic [LANES-1:0][2:0][tfn_pkg::UNIT_W-1:0] out_unit,
	output logic [LANES-1:0]                       out_zero,
	output logic [PW-1:0]                          out_pay
);

	import tfn_pkg::*;

	localparam int NUM_W = DW + UNIT_SH + 1;
	localparam int NW    = ((NUM_W > LW) ? NUM_W : LW) + 1;
	localparam int DSW   = LW + 1 + QUO_W;
	localparam int RW    = (NW > DSW) ? NW : DSW;

	logic                              valid_s [0:QUO_W];
	logic [LANES-1:0][LW-1:0]          len_s   [0:QUO_W];
	logic [LANES-1:0][2:0][RW-1:0]     rem_s   [0:QUO_W];
	logic [LANES-1:0][2:0][QUO_W-1:0]  quo_s   [0:QUO_W];
	logic [LANES-1:0][2:0]             neg_s   [0:QUO_W];
	logic [PW-1:0]                     pay_s   [0:QUO_W];

	// Numerator 2 * |d| * 16384 + len; the divisor is 2 * len.
	always_comb begin
		logic [DW-1:0] mag;
		for (int l = 0; l < LANES; l++) begin
			for (int c = 0; c < 3; c++) begin
				mag = in_vec[l][c][DW-1] ? (~in_vec[l][c] + DW'(1)) : in_vec[l][c];
				rem_s[0][l][c] = RW'({mag, {(UNIT_SH + 1){1'b0}}}) + RW'(in_len[l]);
				quo_s[0][l][c] = '0;
				neg_s[0][l][c] = in_vec[l][c][DW-1];
			end
		end
	end

	assign valid_s[0] = in_valid;
	assign len_s[0]   = in_len;
	assign pay_s[0]   = in_pay;

	genvar g;
	for (g = 0; g < QUO_W; g++) begin : g_stage
		logic [LANES-1:0][2:0][RW-1:0]    rem_n;
		logic [LANES-1:0][2:0][QUO_W-1:0] quo_n;

		// Subtract the divisor shifted to this stage's quotient bit when it fits.
		always_comb begin
			logic [RW-1:0] dsh;
			for (int l = 0; l < LANES; l++) begin
				dsh = RW'({len_s[g][l], 1'b0}) << (QUO_W - 1 - g);
				for (int c = 0; c < 3; c++) begin
					if (rem_s[g][l][c] >= dsh) begin
						rem_n[l][c] = rem_s[g][l][c] - dsh;
						quo_n[l][c] = {quo_s[g][l][c][QUO_W-2:0], 1'b1};
					end else begin
						rem_n[l][c] = rem_s[g][l][c];
						quo_n[l][c] = {quo_s[g][l][c][QUO_W-2:0], 1'b0};
					end
				end
			end
		end

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else if (en) begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		// Data of this stage.
		always_ff @(posedge clk) begin
			if (en) begin
				len_s[g+1] <= len_s[g];
				rem_s[g+1] <= rem_n;
				quo_s[g+1] <= quo_n;
				neg_s[g+1] <= neg_s[g];
				pay_s[g+1] <= pay_s[g];
			end
		end
	end

	// Clamp, restore the sign, and force a zero-length vector to zero.
	always_comb begin
		logic [QUO_W-1:0] qc;
		unit_t            mag_u;
		for (int l = 0; l < LANES; l++) begin
			out_zero[l] = (len_s[QUO_W][l] == '0);
			for (int c = 0; c < 3; c++) begin
				qc    = (quo_s[QUO_W][l][c] > UNIT_ONE) ? UNIT_ONE : quo_s[QUO_W][l][c];
				mag_u = UNIT_W'(qc);
				if (out_zero[l]) begin
					out_unit[l][c] = '0;
				end else if (neg_s[QUO_W][l][c]) begin
					out_unit[l][c] = ~mag_u + UNIT_W'(1);
				end else begin
					out_unit[l][c] = mag_u;
				end
			end
		end
	end

	assign out_valid = valid_s[QUO_W];
	assign out_pay   = pay_s[QUO_W];

endmodule

// ===== hdl/tfn_checker.sv =====
// Port-level checks of the face normal block.
module tfn_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic         m_tuser
);

	// A result that is not taken stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped while stalled");

	// A stalled result keeps its contents.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result transaction changed while stalled");

	// The input side moves exactly when the output register can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output stall");

	// A non-degenerate triangle has a nonzero normal.
	a_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[47:0] != 48'd0)
		else $error("zero normal without degenerate flag");

	// A zero tangent means a zero-length edge.
	a_tangent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[95:48] == 48'd0 |-> m_tuser)
		else $error("zero tangent without degenerate flag");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);

// ===== tb/sv/triangle_face_normal_tb.sv =====
`timescale 1ns / 100ps

module triangle_face_normal_tb;
	import tfn_pkg::*;

	localparam int NUM_RANDOM = 1300;
	localparam int DRAIN_CYCLES = 200;

	// Expected result of one triangle.
	typedef struct {
		logic [15:0] nrm [3];
		logic [15:0] tan [3];
		logic [15:0] bin [3];
		logic        degen;
	} face_result_t;

	typedef logic signed [IN_W-1:0] coord_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [215:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;
	logic         m_tuser;

	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	triangle_face_normal DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
		error_count++;
	endtask

	// Floor integer square root.
	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned bit_val;
		res = 0;
		bit_val = 64'd1 << 62;
		while (bit_val > v) bit_val >>= 2;
		while (bit_val != 0) begin
			if (v >= res + bit_val) begin
				v -= res + bit_val;
				res = (res >> 1) + bit_val;
			end else begin
				res >>= 1;
			end
			bit_val >>= 2;
		end
		return res;
	endfunction

	// Scales a vector to unit length in Q2.14; returns 1 for a zero vector.
	function automatic bit scale_to_unit(ref longint v [3]);
		longint unsigned sum_sq;
		longint unsigned len;
		longint unsigned mag;
		longint unsigned quo;
		sum_sq = 0;
		for (int i = 0; i < 3; i++) begin
			mag = (v[i] < 0) ? -v[i] : v[i];
			sum_sq += mag * mag;
		end
		if (sum_sq == 0) begin
			for (int i = 0; i < 3; i++) v[i] = 0;
			return 1'b1;
		end
		len = isqrt(sum_sq);
		for (int i = 0; i < 3; i++) begin
			mag = ((v[i] < 0) ? -v[i] : v[i]) * 16384;
			quo = (2 * mag + len) / (2 * len);
			if (quo > 16384) quo = 16384;
			v[i] = (v[i] < 0) ? -longint'(quo) : longint'(quo);
		end
		return 1'b0;
	endfunction

	// Computes tangent, binormal and face normal of one triangle.
	function automatic face_result_t face_normal(input logic [215:0] tri_data);
		face_result_t r;
		longint p [9];
		longint t [3];
		longint b [3];
		longint n [3];
		bit dg;
		for (int i = 0; i < 9; i++) p[i] = longint'(coord_t'(tri_data[i*24 +: 24]));
		for (int i = 0; i < 3; i++) begin
			t[i] = p[i] - p[3+i];
			b[i] = p[i] - p[6+i];
		end
		dg = scale_to_unit(t);
		dg |= scale_to_unit(b);
		n[0] = t[1] * b[2] - t[2] * b[1];
		n[1] = t[2] * b[0] - t[0] * b[2];
		n[2] = t[0] * b[1] - t[1] * b[0];
		dg |= scale_to_unit(n);
		for (int i = 0; i < 3; i++) begin
			r.nrm[i] = n[i][15:0];
			r.tan[i] = t[i][15:0];
			r.bin[i] = b[i][15:0];
		end
		r.degen = dg;
		return r;
	endfunction

	// Holds expected results in order and checks arriving ones.
	class face_scoreboard;
		face_result_t pending [$];

		function void note_triangle(logic [215:0] tri_data);
			pending.push_back(face_normal(tri_data));
		endfunction

		task check_result(logic [143:0] data, logic degen);
			face_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", data[15:0], 16'd0);
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (data[i*16 +: 16] !== want.nrm[i])
					report_mismatch($sformatf("normal[%0d]", i), data[i*16 +: 16], want.nrm[i]);
				if (data[(3+i)*16 +: 16] !== want.tan[i])
					report_mismatch($sformatf("tangent[%0d]", i), data[(3+i)*16 +: 16],
						want.tan[i]);
				if (data[(6+i)*16 +: 16] !== want.bin[i])
					report_mismatch($sformatf("binormal[%0d]", i), data[(6+i)*16 +: 16],
						want.bin[i]);
			end
			if (degen !== want.degen)
				report_mismatch("degenerate", 16'(degen), 16'(want.degen));
		endtask
	endclass

	face_scoreboard sb = new();

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sends one triangle, idling at random before it; valid stays high after the
	// transaction so that back-to-back triangles see no gap.
	task automatic send_triangle(input logic [215:0] tri_data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= tri_data;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Random coordinate, often drawn from a small range or an extreme.
	function automatic logic [23:0] rand_coord();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: return 24'($signed($urandom_range(2000)) - 1000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [215:0] rand_triangle();
		logic [215:0] d;
		for (int i = 0; i < 9; i++) d[i*24 +: 24] = rand_coord();
		// Now and then repeat a vertex or make the triangle collinear.
		case ($urandom_range(15))
			0: d[71:0] = d[143:72];
			1: d[143:72] = d[215:144];
			2: for (int i = 0; i < 3; i++)
				d[(6+i)*24 +: 24] = 24'(2 * $signed(d[(3+i)*24 +: 24]) - $signed(d[i*24 +: 24]));
			default: ;
		endcase
		return d;
	endfunction

	function automatic logic [215:0] pack_tri(input int c [9]);
		logic [215:0] d;
		for (int i = 0; i < 9; i++) d[i*24 +: 24] = 24'(c[i]);
		return d;
	endfunction

	// Receiver: stalls at random and checks every result transaction.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, axis edges, zero edges, collinear points.
		send_triangle('0);
		send_triangle({9{24'h7FFFFF}});
		send_triangle({{6{24'h800000}}, {3{24'h7FFFFF}}});
		send_triangle({{3{24'h7FFFFF}}, {3{24'h800000}}, {3{24'h7FFFFF}}});
		send_triangle(pack_tri('{0, 0, 0, 65536, 0, 0, 0, 65536, 0}));
		send_triangle(pack_tri('{0, 0, 0, 0, 0, 65536, 65536, 0, 0}));
		send_triangle(pack_tri('{1, 2, 3, 1, 2, 3, 5, 6, 7}));
		send_triangle(pack_tri('{1, 2, 3, 5, 6, 7, 1, 2, 3}));
		send_triangle(pack_tri('{0, 0, 0, 1, 1, 1, 2, 2, 2}));
		send_triangle(pack_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
		send_triangle(pack_tri('{8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
			8388607, 8388607, -8388608}));
		send_triangle(pack_tri('{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
			8388607, -8388608, 0}));
		send_triangle(pack_tri('{100, 0, 0, 0, 0, 0, 100, 1, 0}));
		send_triangle({9{24'h555555}} ^ {108'd0, {4{27'h2AAAAAA}}});

		// Random phases with changing idle patterns.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 50 : 0;
			recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 18 : 0;
			for (int k = 0; k < NUM_RANDOM / 3; k++) send_triangle(rand_triangle());
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Note each accepted triangle.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_triangle(s_tdata);
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tfn_pkg.sv
hdl/tfn_isqrt.sv
hdl/tfn_unitdiv.sv
hdl/triangle_face_normal.sv
hdl/tfn_checker.sv
tb/sv/triangle_face_normal_tb.sv
